FILE: hw/rtl/amo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package amo_pkg;

  // Upper five instruction bits of the atomic instructions.
  localparam logic [4:0] OP_ADD  = 5'h00;
  localparam logic [4:0] OP_SWAP = 5'h01;
  localparam logic [4:0] OP_LR   = 5'h02;
  localparam logic [4:0] OP_SC   = 5'h03;
  localparam logic [4:0] OP_XOR  = 5'h04;
  localparam logic [4:0] OP_OR   = 5'h08;
  localparam logic [4:0] OP_AND  = 5'h0c;
  localparam logic [4:0] OP_MIN  = 5'h10;
  localparam logic [4:0] OP_MAX  = 5'h14;
  localparam logic [4:0] OP_MINU = 5'h18;
  localparam logic [4:0] OP_MAXU = 5'h1c;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_LR,
    CLS_SC,
    CLS_AMO
  } amo_class_t;

  typedef enum logic [3:0] {
    FN_SWAP,
    FN_ADD,
    FN_XOR,
    FN_AND,
    FN_OR,
    FN_MIN,
    FN_MAX,
    FN_MINU,
    FN_MAXU
  } amo_func_t;

  typedef struct packed {
    logic [4:0]  operation;
    logic        is_doubleword;
    logic [63:0] address;
    logic [63:0] operand;
    logic [63:0] mem_data;
    logic        access_fault;
  } amo_in_t;

  typedef struct packed {
    logic [63:0] rd_value;
    logic        write_enable;
    logic [63:0] write_data;
    logic        fault;
  } amo_out_t;

  // One classified transaction as it waits between the front and the back.
  typedef struct packed {
    amo_class_t  cls;
    amo_func_t   func;
    logic        is_doubleword;
    logic [63:0] address;
    logic [63:0] operand;
    logic [63:0] mem_data;
    logic        access_fault;
  } amo_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/atomic_memory_op_unit.sv
// Atomic memory operation unit: executes one RISC-V atomic instruction
// (LR, SC or a read-modify-write AMO) per input transaction.
// Input channel in_valid/in_ready/in_data carries the operation, size,
// address, register operand, the value read from memory and a fault flag.
// Result channel out_valid/out_ready/out_data returns the destination
// register value, the memory write request and the fault indication.
// Exactly one result transaction is produced for every input transaction,
// in order.
// Flow: an accepted transaction is classified combinationally into a
// two-entry queue and executed from there; its result is registered in
// the output register and held there until the receiver takes it.
// Throughput: one transaction per cycle while the receiver keeps taking
// results, set by the execute stage and its output register.
// When the receiver stalls, the output register holds its result, the
// queue fills and in_ready falls once both queue entries are occupied.
// Reset empties the queue and the output register and clears the
// reservation, so a store-conditional before any load-reserved fails.
`timescale 1ns / 1ps
`default_nettype none

module atomic_memory_op_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  amo_pkg::amo_in_t         in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output amo_pkg::amo_out_t        out_data
);
  import amo_pkg::*;

  logic       push_valid, push_ready;
  amo_entry_t push_entry;
  logic       pop_valid, pop_ready;
  amo_entry_t pop_entry;

  amo_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  amo_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  amo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A faulting transaction discards its results.
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.fault) |->
      (!out_data.write_enable && (out_data.rd_value == '0) && (out_data.write_data == '0)))
    else $error("faulting result carries data");

  // Write data is zero whenever no write is requested.
  a_no_write_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.write_enable) |-> (out_data.write_data == '0))
    else $error("write data without write enable");

  // Nothing is presented on the result channel straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

FILE: hw/rtl/amo_front.sv
`timescale 1ns / 1ps
`default_nettype none

module amo_front (
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  amo_pkg::amo_in_t         in_data,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output amo_pkg::amo_entry_t      push_entry
);
  import amo_pkg::*;

  amo_class_t cls;
  amo_func_t  func;

  always_comb begin
    cls  = CLS_AMO;
    func = FN_SWAP;
    case (in_data.operation)
      OP_LR:   cls = CLS_LR;
      OP_SC:   cls = CLS_SC;
      OP_SWAP: func = FN_SWAP;
      OP_ADD:  func = FN_ADD;
      OP_XOR:  func = FN_XOR;
      OP_AND:  func = FN_AND;
      OP_OR:   func = FN_OR;
      OP_MIN:  func = FN_MIN;
      OP_MAX:  func = FN_MAX;
      OP_MINU: func = FN_MINU;
      OP_MAXU: func = FN_MAXU;
      default: cls = CLS_NONE;
    endcase
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_entry.cls           = cls;
    push_entry.func          = func;
    push_entry.is_doubleword = in_data.is_doubleword;
    push_entry.address       = in_data.address;
    push_entry.operand       = in_data.operand;
    push_entry.mem_data      = in_data.mem_data;
    push_entry.access_fault  = in_data.access_fault;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/amo_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module amo_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  amo_pkg::amo_entry_t      push_entry,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output amo_pkg::amo_entry_t      pop_entry
);
  import amo_pkg::*;

  amo_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/amo_back.sv
`timescale 1ns / 1ps
`default_nettype none

module amo_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  amo_pkg::amo_entry_t      pop_entry,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output amo_pkg::amo_out_t        out_data
);
  import amo_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  amo_out_t    out_data_r, out_data_nxt;
  logic [63:0] resv_addr_r, resv_addr_nxt;
  logic        resv_valid_r, resv_valid_nxt;

  logic        do_pop;
  logic [63:0] mask, oldx, srcx, mem_m, opnd_m, res;
  logic        sc_match;

  // The output register is free when empty or when its transaction leaves now.
  assign pop_ready = !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    mask   = pop_entry.is_doubleword ? '1 : {32'h0, 32'hffff_ffff};
    oldx   = pop_entry.is_doubleword ? pop_entry.mem_data :
             {{32{pop_entry.mem_data[31]}}, pop_entry.mem_data[31:0]};
    srcx   = pop_entry.is_doubleword ? pop_entry.operand :
             {{32{pop_entry.operand[31]}}, pop_entry.operand[31:0]};
    mem_m  = pop_entry.mem_data & mask;
    opnd_m = pop_entry.operand & mask;
    sc_match = resv_valid_r && (resv_addr_r == pop_entry.address);
  end

  always_comb begin
    case (pop_entry.func)
      FN_SWAP: res = pop_entry.operand;
      FN_ADD:  res = pop_entry.mem_data + pop_entry.operand;
      FN_XOR:  res = pop_entry.mem_data ^ pop_entry.operand;
      FN_AND:  res = pop_entry.mem_data & pop_entry.operand;
      FN_OR:   res = pop_entry.mem_data | pop_entry.operand;
      FN_MIN:  res = ($signed(oldx) < $signed(srcx)) ? pop_entry.mem_data : pop_entry.operand;
      FN_MAX:  res = ($signed(srcx) < $signed(oldx)) ? pop_entry.mem_data : pop_entry.operand;
      FN_MINU: res = (mem_m < opnd_m) ? pop_entry.mem_data : pop_entry.operand;
      FN_MAXU: res = (mem_m > opnd_m) ? pop_entry.mem_data : pop_entry.operand;
      default: res = pop_entry.operand;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    resv_addr_nxt  = resv_addr_r;
    resv_valid_nxt = resv_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      case (pop_entry.cls)
        CLS_LR: begin
          if (pop_entry.access_fault) begin
            out_data_nxt.fault = 1'b1;
          end else begin
            out_data_nxt.rd_value = oldx;
            resv_addr_nxt         = pop_entry.address;
            resv_valid_nxt        = 1'b1;
          end
        end
        CLS_SC: begin
          // A failed store-conditional makes no access, so a fault is ignored.
          if (sc_match) begin
            if (pop_entry.access_fault) begin
              out_data_nxt.fault = 1'b1;
            end else begin
              out_data_nxt.write_enable = 1'b1;
              out_data_nxt.write_data   = opnd_m;
            end
          end else begin
            out_data_nxt.rd_value = 64'd1;
          end
          resv_valid_nxt = 1'b0;
        end
        CLS_AMO: begin
          if (pop_entry.access_fault) begin
            out_data_nxt.fault = 1'b1;
          end else begin
            out_data_nxt.rd_value     = oldx;
            out_data_nxt.write_enable = 1'b1;
            out_data_nxt.write_data   = res & mask;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      resv_addr_r  <= '0;
      resv_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      resv_addr_r  <= resv_addr_nxt;
      resv_valid_r <= resv_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
